FILE: hw/rtl/dual_stepper_pulse_generator_unit_macros.svh
// Assertion macros for the pulse generator RTL.
// Included by dspg_ctrl, the module that carries the concurrent checks; no other dependencies.
`ifndef DUAL_STEPPER_PULSE_GENERATOR_UNIT_MACROS_SVH
`define DUAL_STEPPER_PULSE_GENERATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define DSPG_ASSERT_IMPLY(lbl, clk_i, rst_i, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset.
`define DSPG_ASSERT_NEXT(lbl, clk_i, rst_i, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DSPG_ASSERT_IMPLY(lbl, clk_i, rst_i, ante, cons, msg)
`define DSPG_ASSERT_NEXT(lbl, clk_i, rst_i, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/dspg_pkg.sv
// Package for the dual stepper pulse generator: constants, codes and payload types.
// Used by every module of the block; depends on nothing.
package dspg_pkg;

  localparam int TICK_HZ        = 1000000;
  localparam int STEPS_PER_TURN = 3200;
  localparam int ROTATION_LIMIT = 1000000;
  localparam int RATE_LIMIT_HZ  = 100000;

  localparam int OP_W     = 3;
  localparam int DIR_W    = 2;
  localparam int ROT_W    = 20;
  localparam int FREQ_W   = 17;
  localparam int STATUS_W = 2;
  localparam int STEPS_W  = 32;
  localparam int HALF_W   = 26;

  // Divider sizing: the dividend is the fixed tick rate, the divisor is twice the frequency.
  localparam int DSR_W = FREQ_W + 1;
  localparam int DIV_W = $clog2(TICK_HZ + 1);
  localparam int QUO_W = (DIV_W > HALF_W) ? DIV_W : HALF_W;
  localparam int CNT_W = $clog2(DIV_W + 1);

  localparam logic [DIR_W-1:0] DIR_LAST_VALID = 2'd1;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 3'd0,
    OP_START  = 3'd1,
    OP_PAUSE  = 3'd2,
    OP_RESUME = 3'd3,
    OP_STOP   = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_BAD_DIR    = 2'd1,
    ST_RANGE      = 2'd2,
    ST_UNKNOWN_OP = 2'd3
  } status_t;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [DIR_W-1:0]  direction;
    logic [ROT_W-1:0]  rotations;
    logic [FREQ_W-1:0] step_rate;
  } req_t;

  typedef struct packed {
    logic                step_level;
    logic                dir_motor_one;
    logic                dir_motor_two;
    logic                enable_n;
    logic                is_running;
    logic                is_paused;
    logic [STATUS_W-1:0] status;
    logic                motion_done;
  } rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic div_go;
    logic commit;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_start;
    logic start_ok;
    logic div_done;
  } stat_t;

endpackage

FILE: hw/rtl/dspg_div.sv
// Restoring divider: tick rate divided by twice the step frequency, one quotient bit a cycle.
// Depends on dspg_pkg.
module dspg_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic [dspg_pkg::DSR_W-1:0]    divisor,
  output logic                          done,
  output logic [dspg_pkg::HALF_W-1:0]   quotient
);

  logic                          busy;
  logic [dspg_pkg::CNT_W-1:0]    cnt;
  logic [dspg_pkg::DIV_W-1:0]    dvd;
  logic [dspg_pkg::DSR_W-1:0]    dsr;
  logic [dspg_pkg::DSR_W-1:0]    rem;
  logic [dspg_pkg::QUO_W-1:0]    quo;
  logic [dspg_pkg::DSR_W:0]      trial;
  logic [dspg_pkg::DSR_W:0]      diff;
  logic                          fits;

  assign trial = {rem, dvd[dspg_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign fits  = (trial >= {1'b0, dsr});
  assign quotient = quo[dspg_pkg::HALF_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvd  <= dspg_pkg::DIV_W'(dspg_pkg::TICK_HZ);
        dsr  <= divisor;
        rem  <= '0;
        quo  <= '0;
      end else if (busy) begin
        rem <= fits ? diff[dspg_pkg::DSR_W-1:0] : trial[dspg_pkg::DSR_W-1:0];
        quo <= {quo[dspg_pkg::QUO_W-2:0], fits};
        dvd <= {dvd[dspg_pkg::DIV_W-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == dspg_pkg::CNT_W'(dspg_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/dspg_dp.sv
// Datapath: request capture, start checks, step multiplier, motion state and result register.
// Depends on dspg_pkg and dspg_div.
module dspg_dp (
  input  logic            clk,
  input  logic            rst,
  input  dspg_pkg::req_t  req,
  input  dspg_pkg::cmd_t  cmd,
  output dspg_pkg::stat_t stat,
  output dspg_pkg::rsp_t  rsp
);

  dspg_pkg::req_t                 req_q;
  dspg_pkg::op_t                  op;
  dspg_pkg::status_t              chk_status;
  logic [dspg_pkg::STEPS_W-1:0]   steps_prod;
  logic [dspg_pkg::HALF_W-1:0]    div_quo;
  logic                           div_done;

  // Motion state.
  logic                           dir_latched;
  logic [dspg_pkg::STEPS_W-1:0]   steps_left;
  logic [dspg_pkg::HALF_W-1:0]    half_period_ticks;
  logic [dspg_pkg::HALF_W-1:0]    tick_countdown;
  logic                           run_flag;
  logic                           pause_flag;
  logic                           step_lvl;
  logic                           enable_flag;

  logic                           dir_latched_next;
  logic [dspg_pkg::STEPS_W-1:0]   steps_left_next;
  logic [dspg_pkg::HALF_W-1:0]    half_period_ticks_next;
  logic [dspg_pkg::HALF_W-1:0]    tick_countdown_next;
  logic                           run_flag_next;
  logic                           pause_flag_next;
  logic                           step_lvl_next;
  logic                           enable_flag_next;
  dspg_pkg::status_t              status_next;
  logic                           done_next;

  assign op = dspg_pkg::op_t'(req_q.operation);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req;
    end
    steps_prod <= dspg_pkg::STEPS_W'(req_q.rotations)
                * dspg_pkg::STEPS_W'(dspg_pkg::STEPS_PER_TURN);
  end

  // Direction is judged first, then the two ranges.
  always_comb begin
    if (req_q.direction > dspg_pkg::DIR_LAST_VALID) begin
      chk_status = dspg_pkg::ST_BAD_DIR;
    end else if (req_q.rotations == '0
                 || req_q.rotations > dspg_pkg::ROT_W'(dspg_pkg::ROTATION_LIMIT)
                 || req_q.step_rate == '0
                 || req_q.step_rate > dspg_pkg::FREQ_W'(dspg_pkg::RATE_LIMIT_HZ)) begin
      chk_status = dspg_pkg::ST_RANGE;
    end else begin
      chk_status = dspg_pkg::ST_OK;
    end
  end

  assign stat.is_start = (op == dspg_pkg::OP_START);
  assign stat.start_ok = (chk_status == dspg_pkg::ST_OK);
  assign stat.div_done = div_done;

  dspg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (cmd.div_go),
    .divisor  ({req_q.step_rate, 1'b0}),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    dir_latched_next       = dir_latched;
    steps_left_next        = steps_left;
    half_period_ticks_next = half_period_ticks;
    tick_countdown_next    = tick_countdown;
    run_flag_next          = run_flag;
    pause_flag_next        = pause_flag;
    step_lvl_next          = step_lvl;
    enable_flag_next       = enable_flag;
    status_next            = dspg_pkg::ST_OK;
    done_next              = 1'b0;
    unique case (op)
      dspg_pkg::OP_TICK: begin
        if (run_flag && !pause_flag) begin
          if (tick_countdown > dspg_pkg::HALF_W'(1)) begin
            tick_countdown_next = tick_countdown - 1'b1;
          end else begin
            tick_countdown_next = half_period_ticks;
            step_lvl_next       = !step_lvl;
            // A falling edge of STEP completes one step.
            if (step_lvl) begin
              if (steps_left <= dspg_pkg::STEPS_W'(1)) begin
                steps_left_next  = '0;
                run_flag_next    = 1'b0;
                enable_flag_next = 1'b0;
                done_next        = 1'b1;
              end else begin
                steps_left_next = steps_left - 1'b1;
              end
            end
          end
        end
      end
      dspg_pkg::OP_START: begin
        status_next = chk_status;
        if (chk_status == dspg_pkg::ST_OK) begin
          dir_latched_next       = req_q.direction[0];
          steps_left_next        = steps_prod;
          half_period_ticks_next = div_quo;
          tick_countdown_next    = div_quo;
          step_lvl_next          = 1'b0;
          pause_flag_next        = 1'b0;
          run_flag_next          = 1'b1;
          enable_flag_next       = 1'b1;
        end
      end
      dspg_pkg::OP_PAUSE: begin
        if (run_flag && !pause_flag) begin
          pause_flag_next = 1'b1;
        end
        step_lvl_next = 1'b0;
      end
      dspg_pkg::OP_RESUME: begin
        if (run_flag && pause_flag) begin
          pause_flag_next     = 1'b0;
          step_lvl_next       = 1'b0;
          tick_countdown_next = half_period_ticks;
        end
      end
      dspg_pkg::OP_STOP: begin
        run_flag_next          = 1'b0;
        pause_flag_next        = 1'b0;
        step_lvl_next          = 1'b0;
        enable_flag_next       = 1'b0;
        steps_left_next        = '0;
        half_period_ticks_next = '0;
        tick_countdown_next    = '0;
      end
      default: begin
        status_next = dspg_pkg::ST_UNKNOWN_OP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dir_latched       <= 1'b0;
      steps_left        <= '0;
      half_period_ticks <= '0;
      tick_countdown    <= '0;
      run_flag          <= 1'b0;
      pause_flag        <= 1'b0;
      step_lvl          <= 1'b0;
      enable_flag       <= 1'b0;
    end else if (cmd.commit) begin
      dir_latched       <= dir_latched_next;
      steps_left        <= steps_left_next;
      half_period_ticks <= half_period_ticks_next;
      tick_countdown    <= tick_countdown_next;
      run_flag          <= run_flag_next;
      pause_flag        <= pause_flag_next;
      step_lvl          <= step_lvl_next;
      enable_flag       <= enable_flag_next;
    end
  end

  // The result shows the state as it stands once the request has been applied.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp.step_level    <= step_lvl_next;
      rsp.dir_motor_one <= dir_latched_next;
      rsp.dir_motor_two <= !dir_latched_next;
      rsp.enable_n      <= !enable_flag_next;
      rsp.is_running    <= run_flag_next;
      rsp.is_paused     <= pause_flag_next;
      rsp.status        <= status_next;
      rsp.motion_done   <= done_next;
    end
  end

endmodule

FILE: hw/rtl/dspg_ctrl.sv
// Controller: sequences capture, divide and commit, and owns both handshakes.
// Depends on dspg_pkg and the assertion macro header.
`include "dual_stepper_pulse_generator_unit_macros.svh"

module dspg_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  input  dspg_pkg::stat_t stat,
  output dspg_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_COMMIT
  } state_t;

  state_t state;
  logic   rsp_free;

  assign rsp_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd.capture = req_valid && req_ready;
    cmd.div_go  = (state == S_CHECK) && stat.is_start && stat.start_ok;
    cmd.commit  = (state == S_COMMIT) && rsp_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          state <= cmd.div_go ? S_DIV : S_COMMIT;
        end
        S_DIV: begin
          if (stat.div_done) begin
            state <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (rsp_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `DSPG_ASSERT_NEXT(a_accept_to_check, clk, rst, req_valid && req_ready, state == S_CHECK, "accepted request did not move to the check state")
  `DSPG_ASSERT_IMPLY(a_div_done_in_div, clk, rst, stat.div_done, state == S_DIV, "divider finished outside the divide state")
  `DSPG_ASSERT_NEXT(a_commit_gives_rsp, clk, rst, cmd.commit, rsp_valid && state == S_IDLE, "commit did not present a result")
  `DSPG_ASSERT_NEXT(a_div_exits, clk, rst, state == S_DIV, state == S_DIV || state == S_COMMIT, "divide state left for a wrong state")

endmodule

FILE: hw/rtl/dual_stepper_pulse_generator_unit.sv
// Top level of the dual stepper STEP/DIR pulse generator.
// Depends on dspg_pkg, dspg_ctrl, dspg_dp and dspg_div.
//
//   Channel   Handshake               Payload        Direction
//   request   req_valid / req_ready   req   (req_t)  in
//   result    rsp_valid / rsp_ready   rsp   (rsp_t)  out
//
// A tick, pause, resume, stop, unknown operation or rejected start passes from acceptance
// through the check and commit states; a good start also passes through the divide state,
// where the restoring divider yields one quotient bit a cycle. One request is worked on at
// a time; a new one is accepted while a result still waits.
// Reset is synchronous: the motion state returns to stopped, forward, drivers off.
// A stalled result holds the request in the commit step, so no state changes meanwhile.
module dual_stepper_pulse_generator_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  dspg_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output dspg_pkg::rsp_t rsp
);

  // Command and status between the sequencer and the datapath.
  dspg_pkg::cmd_t  cmd;
  dspg_pkg::stat_t stat;

  // The controller steps each request through capture, checking, the optional divide for
  // a good start, and a commit that updates the motion state and the result register
  // together, only once the result register is free.
  dspg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the captured request, the step count multiplier, the divider
  // for the half period and all motion state.
  dspg_dp u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .stat (stat),
    .rsp  (rsp)
  );

endmodule
